// ===== rtl/core/biq_pkg.sv =====
// biq_pkg: types, constants and the microprogram for the biquad section sequencer
// no dependencies; imported by biquad_iir_filter_df2_top

package biq_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int COEF_COUNT = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int STATE_W    = 32;
    localparam int MUL_B_W    = 33;
    localparam int PROD_W     = COEF_W + MUL_B_W;
    localparam int ACC_W      = 64;
    localparam int U_W        = 37;
    localparam int STEP_W     = 4;

    localparam logic [STEP_W-1:0] STEP_LAST = 4'd12;

    // coefficient / register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        COEF_B0   = 3'd0,
        COEF_B1   = 3'd1,
        COEF_B2   = 3'd2,
        COEF_A1   = 3'd3,
        COEF_A2   = 3'd4,
        COEF_GIN  = 3'd5,
        COEF_GOUT = 3'd6
    } coef_sel_t;

    typedef enum logic [2:0] {
        OPB_NONE,
        OPB_X,
        OPB_D1,
        OPB_D2,
        OPB_W,
        OPB_UL,
        OPB_UH
    } opb_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_8,
        SH_16
    } shift_t;

    typedef enum logic [1:0] {
        FLOW_NEXT,
        FLOW_WAIT_IN,
        FLOW_WAIT_OUT
    } flow_t;

    typedef struct packed {
        coef_sel_t a_sel;
        opb_sel_t  b_sel;
        acc_op_t   acc_op;
        shift_t    shift;
        logic      latch_w;
        logic      latch_u;
        logic      finish;
        flow_t     flow;
    } ctrl_t;

    typedef logic signed [COEF_W-1:0] coef_arr_t [COEF_COUNT];

    localparam coef_arr_t COEF_RESET = '{
        24'sd1048576, 24'sd1048576, 24'sd0, -24'sd1032234, 24'sd0, 24'sd8171, 24'sd1048576
    };

    localparam ctrl_t CTRL_NOP = '{COEF_B0, OPB_NONE, ACC_NONE, SH_0, 1'b0, 1'b0, 1'b0,
                                   FLOW_NEXT};

    // microprogram: product issued in step k is accumulated in step k+1
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = CTRL_NOP;
        case (step)
            4'd0:  c.flow = FLOW_WAIT_IN;
            4'd1:  begin c.a_sel = COEF_GIN; c.b_sel = OPB_X;  c.acc_op = ACC_LOAD;
                         c.shift = SH_8; end
            4'd2:  begin c.a_sel = COEF_A1;  c.b_sel = OPB_D1; c.acc_op = ACC_SUB; end
            4'd3:  begin c.a_sel = COEF_A2;  c.b_sel = OPB_D2; c.acc_op = ACC_SUB; end
            4'd4:  begin c.a_sel = COEF_B1;  c.b_sel = OPB_D1; c.acc_op = ACC_LOAD; end
            4'd5:  begin c.a_sel = COEF_B2;  c.b_sel = OPB_D2; c.acc_op = ACC_ADD;
                         c.latch_w = 1'b1; end
            4'd6:  begin c.a_sel = COEF_B0;  c.b_sel = OPB_W;  c.acc_op = ACC_ADD; end
            4'd7:  c = CTRL_NOP;
            4'd8:  c.latch_u = 1'b1;
            4'd9:  begin c.a_sel = COEF_GOUT; c.b_sel = OPB_UL; c.acc_op = ACC_LOAD; end
            4'd10: begin c.a_sel = COEF_GOUT; c.b_sel = OPB_UH; c.acc_op = ACC_ADD;
                         c.shift = SH_16; end
            4'd11: c = CTRL_NOP;
            4'd12: begin c.finish = 1'b1; c.flow = FLOW_WAIT_OUT; end
            default: c = CTRL_NOP;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/biquad_iir_filter_df2_top.sv =====
// biquad_iir_filter_df2_top: direct form II biquad section with input and output gain
// depends on biq_pkg (types, microprogram, reset coefficients)
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata[15:0] sample_in
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata[15:0] sample_out, tuser[0] saturated
// cfg       in   cfg_we (no wait)                cfg_index[2:0], cfg_wdata[23:0]
//
// each sample runs the acceptance step plus twelve microcode steps around a single
// shared 24x33 multiplier (seven products, the output gain product split in two halves)
// s_axis_tready is high only at step 0; the result waits in an output register, so the
// next sample is taken while a result is still pending
// the last step holds only if the output register is still full when the next result is done
// reset clears the step counter, delay pair, output valid and loads the default coefficients

module biquad_iir_filter_df2_top
    import biq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [15:0] sample_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [15:0] sample_out
    output logic                 m_axis_tuser,   // [0] saturated
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_wdata
);

    // sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ctrl_t             ctrl;
    logic              advance;

    // coefficient registers
    coef_arr_t coef_reg;

    // datapath
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [STATE_W-1:0]  d1_reg, d2_reg;
    logic signed [STATE_W-1:0]  w_reg, w_next;
    logic                       sat_w_reg, sat_w_next;
    logic [U_W-1:0]             u_reg;
    logic [COEF_W-1:0]          mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [PROD_W-1:0]          prod_reg;
    acc_op_t                    pend_op_reg;
    shift_t                     pend_shift_reg;
    logic [ACC_W-1:0]           acc_reg, acc_next;
    logic [ACC_W-1:0]           term;

    // rounding of the accumulator
    logic [ACC_W-1:0]      rnd20, rnd28;
    logic                  w_ovf, y_ovf;
    logic [SAMPLE_W-1:0]   y_val;

    // output register
    logic                  out_valid_reg;
    logic [SAMPLE_W-1:0]   out_data_reg;
    logic                  out_sat_reg;

    assign ctrl = ucode(step_reg);

    // ---------------- control ----------------
    always_comb
    begin
        case (ctrl.flow)
            FLOW_WAIT_IN:  advance = s_axis_tvalid;
            FLOW_WAIT_OUT: advance = !out_valid_reg || m_axis_tready;
            default:       advance = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (advance)
        begin
            if (step_reg >= STEP_LAST)
                step_next = '0;
            else
                step_next = step_reg + 1'b1;
        end
    end

    always_comb
    begin
        s_axis_tready = (ctrl.flow == FLOW_WAIT_IN);
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = out_data_reg;
        m_axis_tuser  = out_sat_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= '0;
            pend_op_reg    <= ACC_NONE;
            pend_shift_reg <= SH_0;
        end
        else
        begin
            step_reg       <= step_next;
            pend_op_reg    <= ctrl.acc_op;
            pend_shift_reg <= ctrl.shift;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coef_reg <= COEF_RESET;
        else if (cfg_we && (cfg_index < CFG_IDX_W'(COEF_COUNT)))
            coef_reg[cfg_index] <= cfg_wdata;
    end

    // ---------------- shared multiplier ----------------
    assign mul_a = coef_reg[ctrl.a_sel];

    always_comb
    begin
        case (ctrl.b_sel)
            OPB_X:   mul_b = {{(MUL_B_W-SAMPLE_W){x_reg[SAMPLE_W-1]}}, x_reg};
            OPB_D1:  mul_b = {{(MUL_B_W-STATE_W){d1_reg[STATE_W-1]}}, d1_reg};
            OPB_D2:  mul_b = {{(MUL_B_W-STATE_W){d2_reg[STATE_W-1]}}, d2_reg};
            OPB_W:   mul_b = {{(MUL_B_W-STATE_W){w_reg[STATE_W-1]}}, w_reg};
            // low half unsigned, high half signed
            OPB_UL:  mul_b = {{(MUL_B_W-16){1'b0}}, u_reg[15:0]};
            OPB_UH:  mul_b = {{(MUL_B_W-(U_W-16)){u_reg[U_W-1]}}, u_reg[U_W-1:16]};
            default: mul_b = '0;
        endcase
    end

    // sign-extended operands, product kept to its low PROD_W bits
    always_ff @(posedge clk)
    begin
        prod_reg <= {{MUL_B_W{mul_a[COEF_W-1]}}, mul_a}
                  * {{COEF_W{mul_b[MUL_B_W-1]}}, mul_b};
    end

    // ---------------- accumulator ----------------
    always_comb
    begin
        term = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (pend_shift_reg)
            SH_8:    term = term << 8;
            SH_16:   term = term << 16;
            default: term = term;
        endcase
        case (pend_op_reg)
            ACC_LOAD: acc_next = term;
            ACC_ADD:  acc_next = acc_reg + term;
            ACC_SUB:  acc_next = acc_reg - term;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // round half up, then clip
    always_comb
    begin
        rnd20 = acc_reg + (ACC_W'(1) << 19);
        rnd28 = acc_reg + (ACC_W'(1) << 27);
        w_ovf = !((&rnd20[ACC_W-1:51]) || !(|rnd20[ACC_W-1:51]));
        y_ovf = !((&rnd28[ACC_W-1:43]) || !(|rnd28[ACC_W-1:43]));
        if (w_ovf)
            w_next = rnd20[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}}
                                    : {1'b0, {(STATE_W-1){1'b1}}};
        else
            w_next = rnd20[51:20];
        sat_w_next = w_ovf;
        if (y_ovf)
            y_val = rnd28[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_W-1){1'b1}}};
        else
            y_val = rnd28[43:28];
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            x_reg <= s_axis_tdata;
        if (ctrl.latch_w)
        begin
            w_reg     <= w_next;
            sat_w_reg <= sat_w_next;
        end
        if (ctrl.latch_u)
            u_reg <= rnd20[U_W+19:20];
    end

    // ---------------- delay pair and output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg        <= '0;
            d2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.finish && advance)
            begin
                d2_reg        <= d1_reg;
                d1_reg        <= w_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish && advance)
        begin
            out_data_reg <= y_val;
            out_sat_reg  <= sat_w_reg | y_ovf;
        end
    end

`ifndef ASSERT_OFF
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_LAST)
        else $error("step counter beyond last microcode step");

    a_ready_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (step_reg == '0))
        else $error("input ready outside the acceptance step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (step_reg == STEP_W'(1)))
        else $error("accepted transaction did not start the program");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.finish && advance) |=> m_axis_tvalid)
        else $error("finished sample not presented on output");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.finish && out_valid_reg && !m_axis_tready) |=> (step_reg == STEP_LAST))
        else $error("sequencer left last step while output still pending");
`endif

endmodule
